/* hdl/ple_pkg.sv */
// shared constants and types for the positional list engine
`timescale 1ns / 1ps

package ple_pkg;

  // list capacity and the widths that follow from it
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 8;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int VAL_W    = 32;
  localparam int OUT_W    = 5;

  typedef enum logic [2:0] {
    OP_ADD_FRONT = 3'd0,
    OP_ADD_END   = 3'd1,
    OP_ADD_POS   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_END   = 3'd4,
    OP_DEL_POS   = 3'd5,
    OP_SEARCH    = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_BOUNDS  = 3'd2,
    ST_FULL    = 3'd3,
    ST_MISSING = 3'd4
  } status_t;

endpackage

/* hdl/positional_list_engine_unit.sv */
// positional list engine: ordered list of signed 32-bit values with insert, delete, search
`timescale 1ns / 1ps

// Ordered list of up to ple_pkg::CAPACITY 32-bit values kept front to back in a
// single-port-write, registered-read memory. One command at a time: in_stall is
// high from the transfer of a command until its result has been loaded into the
// output register, so a command may be taken while the previous result still
// waits for out_stall to drop. Every move, compare or shift step goes through
// the one memory read port: an insert at index i shifts the entries from the
// tail down to i, a delete at index i moves the later entries down, a search
// scans from the front to the first match or the end of the list, and error
// cases and op 7 go straight to the result. A search miss on a full list is the worst case.
// Status is ok, empty, out of bounds, full or not found; full is checked before
// the position on insert, empty before the position on delete. found_position
// is the 1-based first match of a search and 0 otherwise; entry_count is the
// count after the command, modulo 32. No clearing pass: entries are only read
// below the count, and those have always been written.
module positional_list_engine_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_op,
  input  logic signed [31:0]            in_value,
  input  logic [7:0]                    in_position,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_status,
  output logic [4:0]                    out_found_position,
  output logic [4:0]                    out_entry_count
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CHK,
    S_INS_MOV,
    S_DEL_CHK,
    S_DEL_MOV,
    S_SRCH_CHK,
    S_SRCH_CMP,
    S_DONE
  } state_t;

  // control state
  state_t                          state_r, state_nxt;
  logic [ple_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [ple_pkg::CNT_W-1:0]       k_r, k_nxt;       // walking index
  logic [ple_pkg::IDX_W-1:0]       idx_r, idx_nxt;   // insert target index
  logic [ple_pkg::VAL_W-1:0]       value_r, value_nxt;
  ple_pkg::status_t                stat_r, stat_nxt;
  logic [ple_pkg::CNT_W-1:0]       found_r, found_nxt;

  // result register
  logic                            out_valid_r, out_valid_nxt;
  ple_pkg::status_t                out_status_r, out_status_nxt;
  logic [ple_pkg::CNT_W-1:0]       out_found_r, out_found_nxt;
  logic [ple_pkg::CNT_W-1:0]       out_count_r, out_count_nxt;

  // list storage
  logic [ple_pkg::VAL_W-1:0]       mem [ple_pkg::CAPACITY];
  logic                            mem_we;
  logic [ple_pkg::IDX_W-1:0]       mem_waddr;
  logic [ple_pkg::VAL_W-1:0]       mem_wdata;
  logic [ple_pkg::IDX_W-1:0]       mem_raddr;
  logic [ple_pkg::VAL_W-1:0]       rd_data_r;

  // command decode helpers, widened so pos and count+1 compare without wrap
  logic                            in_xfer;
  logic [ple_pkg::CMP_W-1:0]       pos_w;
  logic [ple_pkg::CMP_W-1:0]       cnt_w;
  logic                            list_full;
  logic                            list_empty;
  logic                            out_free;

  assign in_xfer    = in_valid && !in_stall;
  assign pos_w      = ple_pkg::CMP_W'(in_position);
  assign cnt_w      = ple_pkg::CMP_W'(count_r);
  assign list_full  = (count_r == ple_pkg::CNT_W'(ple_pkg::CAPACITY));
  assign list_empty = (count_r == '0);
  assign out_free   = !out_valid_r || !out_stall;

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = ple_pkg::OUT_W'(out_found_r);
  assign out_entry_count    = ple_pkg::OUT_W'(out_count_r);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    k_nxt          = k_r;
    idx_nxt        = idx_r;
    value_nxt      = value_r;
    stat_nxt       = stat_r;
    found_nxt      = found_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    mem_waddr      = k_r[ple_pkg::IDX_W-1:0];
    mem_wdata      = rd_data_r;
    mem_raddr      = k_r[ple_pkg::IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          value_nxt = in_value;
          stat_nxt  = ple_pkg::ST_OK;
          found_nxt = '0;
          state_nxt = S_DONE;
          case (ple_pkg::op_t'(in_op))
            ple_pkg::OP_ADD_FRONT, ple_pkg::OP_ADD_END, ple_pkg::OP_ADD_POS: begin
              k_nxt = count_r;
              if (list_full) begin
                stat_nxt = ple_pkg::ST_FULL;
              end else if (ple_pkg::op_t'(in_op) == ple_pkg::OP_ADD_FRONT) begin
                idx_nxt   = '0;
                state_nxt = S_INS_CHK;
              end else if (ple_pkg::op_t'(in_op) == ple_pkg::OP_ADD_END) begin
                idx_nxt   = count_r[ple_pkg::IDX_W-1:0];
                state_nxt = S_INS_CHK;
              end else if (pos_w == '0 || pos_w > cnt_w + ple_pkg::CMP_W'(1)) begin
                stat_nxt = ple_pkg::ST_BOUNDS;
              end else begin
                idx_nxt   = ple_pkg::IDX_W'(pos_w - ple_pkg::CMP_W'(1));
                state_nxt = S_INS_CHK;
              end
            end
            ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_END, ple_pkg::OP_DEL_POS: begin
              if (list_empty) begin
                stat_nxt = ple_pkg::ST_EMPTY;
              end else if (ple_pkg::op_t'(in_op) == ple_pkg::OP_DEL_FRONT) begin
                k_nxt     = '0;
                state_nxt = S_DEL_CHK;
              end else if (ple_pkg::op_t'(in_op) == ple_pkg::OP_DEL_END) begin
                k_nxt     = count_r - ple_pkg::CNT_W'(1);
                state_nxt = S_DEL_CHK;
              end else if (pos_w == '0 || pos_w > cnt_w) begin
                stat_nxt = ple_pkg::ST_BOUNDS;
              end else begin
                k_nxt     = ple_pkg::CNT_W'(pos_w - ple_pkg::CMP_W'(1));
                state_nxt = S_DEL_CHK;
              end
            end
            ple_pkg::OP_SEARCH: begin
              k_nxt     = '0;
              stat_nxt  = ple_pkg::ST_MISSING;
              state_nxt = S_SRCH_CHK;
            end
            default: begin
              // unused op code: plain ok, list untouched
            end
          endcase
        end
      end

      // shift entries up one slot from the tail down to the target
      S_INS_CHK: begin
        if (k_r == ple_pkg::CNT_W'(idx_r)) begin
          mem_we    = 1'b1;
          mem_waddr = idx_r;
          mem_wdata = value_r;
          count_nxt = count_r + ple_pkg::CNT_W'(1);
          state_nxt = S_DONE;
        end else begin
          mem_raddr = ple_pkg::IDX_W'(k_r - ple_pkg::CNT_W'(1));
          state_nxt = S_INS_MOV;
        end
      end
      S_INS_MOV: begin
        mem_we    = 1'b1;
        k_nxt     = k_r - ple_pkg::CNT_W'(1);
        state_nxt = S_INS_CHK;
      end

      // close the gap by moving later entries down one slot
      S_DEL_CHK: begin
        if (k_r + ple_pkg::CNT_W'(1) == count_r) begin
          count_nxt = count_r - ple_pkg::CNT_W'(1);
          state_nxt = S_DONE;
        end else begin
          mem_raddr = ple_pkg::IDX_W'(k_r + ple_pkg::CNT_W'(1));
          state_nxt = S_DEL_MOV;
        end
      end
      S_DEL_MOV: begin
        mem_we    = 1'b1;
        k_nxt     = k_r + ple_pkg::CNT_W'(1);
        state_nxt = S_DEL_CHK;
      end

      // front-to-back scan, first match wins
      S_SRCH_CHK: begin
        if (k_r == count_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (rd_data_r == value_r) begin
          stat_nxt  = ple_pkg::ST_OK;
          found_nxt = k_r + ple_pkg::CNT_W'(1);
          state_nxt = S_DONE;
        end else begin
          k_nxt     = k_r + ple_pkg::CNT_W'(1);
          state_nxt = S_SRCH_CHK;
        end
      end

      // hand the result over once the output register is free
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat_r;
          out_found_nxt  = found_r;
          out_count_nxt  = count_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    k_r          <= k_nxt;
    idx_r        <= idx_nxt;
    value_r      <= value_nxt;
    stat_r       <= stat_nxt;
    found_r      <= found_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

  // list memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

`ifndef ASSERT_OFF
  // a command transfer always starts the sequencer
  a_xfer_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_stall)
    else $error("command transfer did not start the sequencer");

  // the count stays within the capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ple_pkg::CNT_W'(ple_pkg::CAPACITY))
    else $error("entry count above capacity");

  // one command moves the count by at most one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + 1'b1 || count_r + 1'b1 == $past(count_r)))
    else $error("entry count jumped by more than one");
`endif

endmodule
